@@ sv/tvve_pkg.sv @@
package tvve_pkg;

  // Input item modes
  typedef enum logic [3:0] {
    MODE_BYTE    = 4'd0,
    MODE_INT32   = 4'd1,
    MODE_INT64   = 4'd2,
    MODE_FLOAT   = 4'd3,
    MODE_BOOL    = 4'd4,
    MODE_ITRIPLE = 4'd5,
    MODE_FPAIR   = 4'd6,
    MODE_FTRIPLE = 4'd7,
    MODE_END     = 4'd8
  } mode_t;

  // Type bytes on the wire
  localparam logic [7:0] TYPE_BYTE  = 8'd0;
  localparam logic [7:0] TYPE_INT   = 8'd1;
  localparam logic [7:0] TYPE_FLOAT = 8'd2;
  localparam logic [7:0] TYPE_BOOL  = 8'd7;
  localparam logic [7:0] TYPE_FVEC  = 8'd8;
  localparam logic [7:0] TYPE_IVEC  = 8'd9;
  localparam logic [7:0] TYPE_NONE  = 8'd0;

  localparam logic [7:0] END_MARK = 8'hFF;

  // Decoded job handed from the input stage to the serialiser
  typedef struct packed {
    logic        end_mark;   // single 0xFF byte only
    logic [7:0]  id_byte;
    logic [7:0]  type_byte;
    logic        is_varint;  // payload segments are varints, else raw bytes
    logic [2:0]  raw_cnt;    // bytes per raw segment, 1..4
    logic [1:0]  seg_more;   // segments after the first
    logic [63:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
  } job_t;

  typedef struct packed {
    logic valid;  // job register holds an item
    logic drop;   // item accepted this cycle is filtered out
  } jstat_t;

  typedef struct packed {
    logic take;   // serialiser loads the job this cycle
    logic idle;   // no item in the serialiser
  } sstat_t;

endpackage

@@ sv/tvve_job_reg.sv @@
module tvve_job_reg
  import tvve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        dirty_only,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_param_id,
  input  logic        in_dirty,
  input  logic [63:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic [31:0] in_value_c,
  input  sstat_t      sstat,
  output job_t        job,
  output jstat_t      jstat
);

  logic  job_valid_r;
  job_t  job_r;
  job_t  job_nxt;
  mode_t mode;
  logic  accept;
  logic  drop;

  assign mode   = mode_t'(in_mode);
  assign drop   = (mode != MODE_END) && dirty_only && !in_dirty;
  assign in_stall = job_valid_r && !sstat.take;
  assign accept = in_valid && !in_stall;

  // decode the item into a segment plan
  always_comb begin
    job_nxt           = '0;
    job_nxt.id_byte   = in_param_id[7:0];
    job_nxt.v1        = in_value_b;
    job_nxt.v2        = in_value_c;
    job_nxt.raw_cnt   = 3'd1;
    case (mode)
      MODE_BYTE: begin
        job_nxt.type_byte = TYPE_BYTE;
        job_nxt.v0        = in_value_a;
      end
      MODE_INT32: begin
        job_nxt.type_byte = TYPE_INT;
        job_nxt.is_varint = 1'b1;
        job_nxt.v0        = {32'd0, in_value_a[31:0]};
      end
      MODE_INT64: begin
        job_nxt.type_byte = TYPE_INT;
        job_nxt.is_varint = 1'b1;
        job_nxt.v0        = in_value_a;
      end
      MODE_FLOAT: begin
        job_nxt.type_byte = TYPE_FLOAT;
        job_nxt.raw_cnt   = 3'd4;
        job_nxt.v0        = {32'd0, in_value_a[31:0]};
      end
      MODE_BOOL: begin
        job_nxt.type_byte = TYPE_BOOL;
        job_nxt.v0        = {63'd0, |in_value_a};
      end
      MODE_ITRIPLE: begin
        job_nxt.type_byte = TYPE_IVEC;
        job_nxt.is_varint = 1'b1;
        job_nxt.seg_more  = 2'd2;
        job_nxt.v0        = {32'd0, in_value_a[31:0]};
      end
      MODE_FPAIR: begin
        job_nxt.type_byte = TYPE_FVEC;
        job_nxt.raw_cnt   = 3'd4;
        job_nxt.seg_more  = 2'd1;
        job_nxt.v0        = {32'd0, in_value_a[31:0]};
      end
      MODE_FTRIPLE: begin
        job_nxt.type_byte = TYPE_FVEC;
        job_nxt.raw_cnt   = 3'd4;
        job_nxt.seg_more  = 2'd2;
        job_nxt.v0        = {32'd0, in_value_a[31:0]};
      end
      MODE_END: begin
        job_nxt.end_mark  = 1'b1;
      end
      default: begin
        job_nxt.type_byte = TYPE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (accept) begin
      job_valid_r <= !drop;
    end else if (sstat.take) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job        = job_r;
  assign jstat.valid = job_valid_r;
  assign jstat.drop  = accept && drop;

endmodule

@@ sv/tvve_serializer.sv @@
module tvve_serializer
  import tvve_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  jstat_t     jstat,
  output sstat_t     sstat,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ID   = 4'b0010,
    PH_TYPE = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic        end_r;
  logic [7:0]  id_r;
  logic [7:0]  type_r;
  logic        var_r;
  logic [2:0]  cnt_ld_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  seg_r, seg_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [31:0] nb_r, nb_nxt;
  logic [31:0] nc_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic       rest_nz;
  logic       seg_done;
  logic [7:0] pay_byte;
  logic [7:0] byte_now;
  logic       last_now;
  logic       adv;
  logic       emit;
  logic       ready;
  logic       take;

  assign rest_nz  = |cur_r[63:7];
  assign seg_done = var_r ? !rest_nz : (cnt_r == 3'd1);
  assign pay_byte = var_r ? {rest_nz, cur_r[6:0]} : cur_r[7:0];

  always_comb begin
    byte_now = 8'd0;
    last_now = 1'b0;
    case (ph_r)
      PH_ID: begin
        byte_now = end_r ? END_MARK : id_r;
        last_now = end_r;
      end
      PH_TYPE: begin
        byte_now = type_r;
      end
      PH_PAY: begin
        byte_now = pay_byte;
        last_now = seg_done && (seg_r == 2'd0);
      end
      default: begin
        byte_now = 8'd0;
      end
    endcase
  end

  assign adv   = !out_valid_r || !out_stall;
  assign emit  = adv && (ph_r != PH_IDLE);
  assign ready = (ph_r == PH_IDLE) || (emit && last_now);
  assign take  = jstat.valid && ready;

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    seg_nxt = seg_r;
    cur_nxt = cur_r;
    nb_nxt  = nb_r;
    if (take) begin
      ph_nxt  = PH_ID;
      cnt_nxt = job.raw_cnt;
      seg_nxt = job.seg_more;
      cur_nxt = job.v0;
      nb_nxt  = job.v1;
    end else if (ready) begin
      ph_nxt = PH_IDLE;
    end else if (emit) begin
      case (ph_r)
        PH_ID:   ph_nxt = PH_TYPE;
        PH_TYPE: ph_nxt = PH_PAY;
        default: begin
          if (seg_done) begin
            cur_nxt = {32'd0, nb_r};
            nb_nxt  = nc_r;
            seg_nxt = seg_r - 2'd1;
            cnt_nxt = cnt_ld_r;
          end else begin
            cur_nxt = var_r ? (cur_r >> 7) : (cur_r >> 8);
            cnt_nxt = cnt_r - 3'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (adv) begin
        out_valid_r <= (ph_r != PH_IDLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    seg_r <= seg_nxt;
    cur_r <= cur_nxt;
    nb_r  <= nb_nxt;
    if (take) begin
      end_r    <= job.end_mark;
      id_r     <= job.id_byte;
      type_r   <= job.type_byte;
      var_r    <= job.is_varint;
      cnt_ld_r <= job.raw_cnt;
      nc_r     <= job.v2;
    end
    if (adv) begin
      out_byte_r <= byte_now;
      out_last_r <= last_now;
    end
  end

  assign sstat.take    = take;
  assign sstat.idle    = (ph_r == PH_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

@@ sv/tagged_value_varint_encoder.sv @@
// The first byte of an item passes the job register, the serialiser phase
// register and the result register before it reaches out_*. Throughput: one
// byte per cycle while out_stall is low; an item has 1 to 17 bytes. The next
// item waits in the input register, so items run back to back with no gap.
// Reset (rst_n, synchronous, active low): clears dirty_only, drops all items.
module tagged_value_varint_encoder
  import tvve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration: dirty_only
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_param_id,
  input  logic        in_dirty,
  input  logic [63:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic [31:0] in_value_c,
  // encoded byte stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  // Dataflow:
  //   input port -> tvve_job_reg (decode into a segment plan, filter clean
  //   entries) -> tvve_serializer (walk id, type and payload segments, one
  //   byte per cycle while out_stall allows) -> result register.
  // Varints shift the working value right by seven per byte and set the
  // continuation bit while anything is left above; raw words shift by eight.

  logic   dirty_only_r;
  job_t   job;
  jstat_t jstat;
  sstat_t sstat;

  // hold the filter switch; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_only_r <= 1'b0;
    end else if (cfg_wr_en) begin
      dirty_only_r <= cfg_wr_data;
    end
  end

  // decode and park the next item while the current one drains
  tvve_job_reg u_job (
    .clk         (clk),
    .rst_n       (rst_n),
    .dirty_only  (dirty_only_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_param_id (in_param_id),
    .in_dirty    (in_dirty),
    .in_value_a  (in_value_a),
    .in_value_b  (in_value_b),
    .in_value_c  (in_value_c),
    .sstat       (sstat),
    .job         (job),
    .jstat       (jstat)
  );

  // emit the bytes; the result register decouples out_stall
  tvve_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (job),
    .jstat         (jstat),
    .sstat         (sstat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

`ifndef ASSERT_OFF
  // a filtered item never occupies the job register
  a_drop_not_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    jstat.drop |=> !jstat.valid)
    else $error("filtered item loaded into job register");

  // a byte that is not the last of its item leaves the serialiser busy
  a_mid_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_byte) |-> !sstat.idle)
    else $error("serialiser idle in the middle of an item");

  // the serialiser only loads a job that is present
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sstat.take |-> jstat.valid)
    else $error("serialiser took an empty job register");
`endif

endmodule
